/* rtl/core/gccc_pkg.sv */
// Shared constants and types of the grid coast cell counter.
package gccc_pkg;

  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 21;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam logic [CHAR_W-1:0] CHAR_LAND = 8'h23;  // '#'
  localparam logic [CHAR_W-1:0] CHAR_SEA  = 8'h2E;  // '.'

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_SEA  = 2'd1,
    CLS_LAND = 2'd2
  } cls_t;

  // Cell tag: class plus a mark that a land cell is already counted.
  typedef struct packed {
    logic done;
    cls_t cls;
  } tag_t;

  // Per-item command to the line of cells.
  typedef struct packed {
    logic shift;
    tag_t tag;
  } line_ctl_t;

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_t;

endpackage

/* rtl/core/gccc_if.sv */
// Item channels of the grid coast cell counter: map cells in, totals out.
interface gccc_pix_if import gccc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink   (input valid, input cell_char, output ready);
endinterface

interface gccc_cnt_if import gccc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] coast_count;

  modport source (output valid, output coast_count, input ready);
  modport sink   (input valid, input coast_count, output ready);
endinterface

/* rtl/core/gccc_cell.sv */
// One cell of the line store: holds one tag, takes the new tag or its neighbor's.
module gccc_cell import gccc_pkg::*; (
  input  logic      clk,
  input  line_ctl_t ctl,
  input  logic      ins,
  input  tag_t      nbr,
  output tag_t      tag
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag <= ins ? ctl.tag : nbr;
    end
  end

endmodule

/* rtl/core/gccc_line.sv */
// Line of cells holding the previous row; the head cell gives the tag above.
module gccc_line import gccc_pkg::*; #(
  parameter int N_CELLS = MAX_COLS_DEF - 1,
  parameter int IW      = $clog2(MAX_COLS_DEF)
) (
  input  logic          clk,
  input  line_ctl_t     ctl,
  input  logic [IW-1:0] ins_at,
  output tag_t          head
);

  tag_t chain [N_CELLS+1];

  assign chain[N_CELLS] = ctl.tag;
  assign head           = chain[0];

  // Enter the new tag at ins_at, advance everything below it toward the head.
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    gccc_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .ins (ins_at == IW'(i)),
      .nbr (chain[i+1]),
      .tag (chain[i])
    );
  end

endmodule

/* rtl/core/grid_coast_cell_counter.sv */
// Top level of the grid coast cell counter: classify, count, line store, APB registers.
// Throughput: one map cell per cycle with no bubbles between rows or maps; the only stall
// holds a map's last cell while the previous total still waits to be taken.
// The total is registered and shows on the output in the cycle after the map's last cell is accepted.
// Each cell is resolved in its accept cycle against the left tag register and the head of
// a line of MAX_COLS-1 tag cells that advances one step per accepted cell.
// Reset clears positions, the running count and the output valid, and sets both size
// registers to 1; the line of cells is not cleared, row 0 of every map fills it first.
module grid_coast_cell_counter import gccc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  gccc_pix_if.sink           pixel,
  gccc_cnt_if.source         total
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  // Map size registers and the effective sizes after clamping.
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  logic [RW:0]      rows_eff;
  logic [CW:0]      cols_eff;

  // Scan position and per-map state.
  logic [CW-1:0]      col_index;
  logic [RW-1:0]      row_index;
  tag_t               prev_tag;
  logic [COUNT_W-1:0] running_count;
  logic [COUNT_W-1:0] running_count_next;
  logic               out_valid;

  logic     cfg_wr;
  reg_idx_t reg_idx;
  logic     accept;
  logic     last_col;
  logic     last_row;
  logic     at_last;
  logic     have_up;
  logic     have_left;
  cls_t     cur_cls;
  tag_t     left_tag;
  tag_t     up_tag;
  tag_t     head_tag;
  tag_t     cur_tag;
  logic     land_hit;
  logic     left_hit;
  logic     up_hit;
  logic [1:0]         inc;
  logic [COUNT_W:0]   sum;
  line_ctl_t          line_ctl;
  logic [CW-1:0]      ins_at;

  // ---------------------------------------------------------------------------
  // Configuration port: every write lands at the access cycle, pready tied high.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count);
      REG_COL_COUNT: prdata = PDATA_W'(col_count);
      default:       prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (row_count == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows_eff = (RW+1)'(MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(row_count);
    end
    if (col_count == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(col_count) > 32'(MAX_COLS)) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(col_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: hold the input only when the map's last cell would need an output
  // register that is still full.
  // ---------------------------------------------------------------------------
  assign last_col    = (({1'b0, col_index} + (CW+1)'(1)) == cols_eff);
  assign last_row    = (({1'b0, row_index} + (RW+1)'(1)) == rows_eff);
  assign at_last     = last_col && last_row;
  assign pixel.ready = !at_last || !out_valid || total.ready;
  assign accept      = pixel.valid && pixel.ready;
  assign total.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Neighbor resolution. The tag above comes from the head of the line; with a
  // single column the cell above is simply the previous cell.
  // ---------------------------------------------------------------------------
  assign have_up   = (row_index != '0);
  assign have_left = (col_index != '0);

  always_comb begin
    case (pixel.cell_char)
      CHAR_LAND: cur_cls = CLS_LAND;
      CHAR_SEA:  cur_cls = CLS_SEA;
      default:   cur_cls = CLS_NONE;
    endcase
  end

  assign left_tag = have_left ? prev_tag : tag_t'('0);
  assign up_tag   = (cols_eff == (CW+1)'(1)) ? prev_tag : head_tag;

  // Land next to sea counts itself; sea counts open land on its left and above.
  assign land_hit = (cur_cls == CLS_LAND) &&
                    ((have_left && left_tag.cls == CLS_SEA) ||
                     (have_up && up_tag.cls == CLS_SEA));
  assign left_hit = (cur_cls == CLS_SEA) && have_left &&
                    (left_tag.cls == CLS_LAND) && !left_tag.done;
  assign up_hit   = (cur_cls == CLS_SEA) && have_up &&
                    (up_tag.cls == CLS_LAND) && !up_tag.done;

  assign cur_tag = '{done: land_hit, cls: cur_cls};

  assign inc = {1'b0, land_hit} + {1'b0, left_hit} + {1'b0, up_hit};
  assign sum = {1'b0, running_count} + (COUNT_W+1)'(inc);
  assign running_count_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  // ---------------------------------------------------------------------------
  // Line store. The previous cell's tag is final once this cell is seen, so it
  // enters the line now; entering at cols-2 puts it at the head one row later.
  // ---------------------------------------------------------------------------
  assign line_ctl.shift    = accept;
  assign line_ctl.tag.done = prev_tag.done | left_hit;
  assign line_ctl.tag.cls  = prev_tag.cls;
  assign ins_at            = CW'(cols_eff - (CW+1)'(2));

  gccc_line #(
    .N_CELLS (MAX_COLS - 1),
    .IW      (CW)
  ) u_line (
    .clk    (clk),
    .ctl    (line_ctl),
    .ins_at (ins_at),
    .head   (head_tag)
  );

  // ---------------------------------------------------------------------------
  // Position, running count and size registers. A size write abandons the map.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= CFG_W'(1);
      col_count     <= CFG_W'(1);
      col_index     <= '0;
      row_index     <= '0;
      prev_tag      <= '0;
      running_count <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_COUNT: row_count <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
      col_index     <= '0;
      row_index     <= '0;
      prev_tag      <= '0;
      running_count <= '0;
    end else if (accept) begin
      prev_tag <= cur_tag;
      if (last_col) begin
        col_index <= '0;
        if (last_row) begin
          row_index     <= '0;
          running_count <= '0;
        end else begin
          row_index     <= row_index + RW'(1);
          running_count <= running_count_next;
        end
      end else begin
        col_index     <= col_index + CW'(1);
        running_count <= running_count_next;
      end
    end
  end

  // Output register: load the total on the last cell, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && at_last) begin
      out_valid <= 1'b1;
    end else if (total.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && at_last) begin
      total.coast_count <= running_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_last_gives_total: assert property (@(posedge clk) disable iff (rst)
    accept && at_last |=> total.valid)
    else $error("last cell of a map did not raise a total");

  a_count_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && at_last |=> running_count == '0)
    else $error("running count not cleared after a map");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_index} < cols_eff) && ({1'b0, row_index} < rows_eff))
    else $error("scan position outside the map");

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    at_last && total.valid && !total.ready |-> !pixel.ready)
    else $error("last cell taken while the total is still pending");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> col_index == '0 && row_index == '0 && running_count == '0)
    else $error("size write did not restart the map");

endmodule
